>>> design/ssd_pkg.sv
// Shared types and constants for the shifted image SSD block.
// Used by every module of the block but ssd_ram; depends on nothing.
`default_nettype none

package ssd_pkg;

    // Default storage dimensions of both images.
    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;

    // Fixed field widths.
    localparam int PIX_W   = 8;
    localparam int POS_W   = 8;
    localparam int SHIFT_W = 9;
    localparam int CFG_W   = 9;
    localparam int SUM_W   = 32;
    localparam int APB_W   = 32;
    localparam int ADDR_W  = 3;

    // Reset value of both dimension registers.
    localparam logic [CFG_W-1:0] CFG_DIM_RESET = 9'd256;

    // Input commands.
    typedef enum logic [1:0] {
        CMD_LOAD_STATIC = 2'd0,
        CMD_LOAD_MOVING = 2'd1,
        CMD_EVALUATE    = 2'd2
    } t_command;

    // Register index, taken from paddr[2].
    typedef enum logic {
        REG_ACTIVE_WIDTH  = 1'b0,
        REG_ACTIVE_HEIGHT = 1'b1
    } t_reg_index;

    // Scan sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } t_scan_state;

    // Control that travels with each pixel read.
    typedef struct packed {
        logic start;
        logic valid;
        logic last;
    } t_scan_ctl;

endpackage

`default_nettype wire

>>> design/ssd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package needed.
`default_nettype none

module ssd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

>>> design/ssd_scan.sv
// Scan sequencer: walks the static frame and issues paired memory reads.
// Depends on ssd_pkg.
`default_nettype none

module ssd_scan
    import ssd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    localparam int XW = $clog2(MAX_WIDTH),
    localparam int YW = $clog2(MAX_HEIGHT),
    localparam int AW = XW + YW
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic signed [SHIFT_W-1:0] i_shift_x,
    input  wire logic signed [SHIFT_W-1:0] i_shift_y,
    input  wire logic        [CFG_W-1:0]   i_cfg_width,
    input  wire logic        [CFG_W-1:0]   i_cfg_height,
    input  wire logic                      i_done,
    input  wire logic                      i_out_free,
    output logic                           o_busy,
    output logic                           o_result_load,
    output t_scan_ctl                      o_ctl,
    output logic             [AW-1:0]      o_static_addr,
    output logic             [AW-1:0]      o_moving_addr
);

    localparam int CW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 1);
    localparam int SXW = ((CW > SHIFT_W) ? CW : SHIFT_W) + 2;
    localparam int SYW = ((RW > SHIFT_W) ? RW : SHIFT_W) + 2;

    t_scan_state r_state, n_state;

    logic        [XW-1:0]      r_x;
    logic        [YW-1:0]      r_y;
    logic        [CW-1:0]      r_w;
    logic        [RW-1:0]      r_h;
    logic signed [SHIFT_W-1:0] r_sx;
    logic signed [SHIFT_W-1:0] r_sy;

    logic        [CW-1:0]      n_w;
    logic        [RW-1:0]      n_h;
    logic signed [SXW-1:0]     mx;
    logic signed [SYW-1:0]     my;
    logic signed [SXW-1:0]     w_s;
    logic signed [SYW-1:0]     h_s;
    logic                      mx_ok;
    logic                      my_ok;
    logic                      x_last;
    logic                      y_last;

    // Clamp the dimension registers to 1..MAX at the start of an evaluation.
    always_comb begin
        if (i_cfg_width == '0) begin
            n_w = CW'(1);
        end else if (32'(i_cfg_width) > MAX_WIDTH) begin
            n_w = CW'(MAX_WIDTH);
        end else begin
            n_w = CW'(i_cfg_width);
        end
        if (i_cfg_height == '0) begin
            n_h = RW'(1);
        end else if (32'(i_cfg_height) > MAX_HEIGHT) begin
            n_h = RW'(MAX_HEIGHT);
        end else begin
            n_h = RW'(i_cfg_height);
        end
    end

    // Moving image coordinate and its bounds test.
    always_comb begin
        mx    = signed'(SXW'({1'b0, r_x})) - SXW'(r_sx);
        my    = signed'(SYW'({1'b0, r_y})) - SYW'(r_sy);
        w_s   = signed'(SXW'(r_w));
        h_s   = signed'(SYW'(r_h));
        mx_ok = !mx[SXW-1] && (mx < w_s);
        my_ok = !my[SYW-1] && (my < h_s);
        x_last = (CW'(r_x) == r_w - CW'(1));
        y_last = (RW'(r_y) == r_h - RW'(1));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (x_last && y_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (i_done && i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_busy        = 1'b0;
        o_result_load = 1'b0;
        o_ctl         = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_ctl.start = i_start;
            end
            ST_SCAN: begin
                o_busy      = 1'b1;
                o_ctl.valid = mx_ok && my_ok;
                o_ctl.last  = x_last && y_last;
            end
            ST_DRAIN: begin
                o_busy        = 1'b1;
                o_result_load = i_done && i_out_free;
            end
            default: begin
                o_busy = 1'b0;
            end
        endcase
    end

    // Read addresses, row-major with the column in the low bits.
    assign o_static_addr = {r_y, r_x};
    assign o_moving_addr = {my[YW-1:0], mx[XW-1:0]};

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Scan counters and the parameters of the current evaluation.
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_x  <= '0;
            r_y  <= '0;
            r_w  <= n_w;
            r_h  <= n_h;
            r_sx <= i_shift_x;
            r_sy <= i_shift_y;
        end else if (r_state == ST_SCAN) begin
            if (x_last) begin
                r_x <= '0;
                r_y <= r_y + YW'(1);
            end else begin
                r_x <= r_x + XW'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> design/ssd_accum.sv
// Difference, square and saturating accumulation of paired pixels.
// Depends on ssd_pkg.
`default_nettype none

module ssd_accum
    import ssd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_scan_ctl        i_ctl,
    input  wire logic [PIX_W-1:0] i_static_pix,
    input  wire logic [PIX_W-1:0] i_moving_pix,
    output logic                  o_done,
    output logic      [SUM_W-1:0] o_sum
);

    logic                     r_s1_valid;
    logic                     r_s1_last;
    logic                     r_s2_valid;
    logic                     r_s2_last;
    logic [2*PIX_W-1:0]       r_sq;
    logic [SUM_W-1:0]         r_acc;
    logic                     r_done;

    logic signed [PIX_W:0]     diff;
    logic signed [2*PIX_W+1:0] prod;
    logic        [SUM_W:0]     sum_ext;

    // Square of the pixel difference; it always fits in 16 bits.
    always_comb begin
        diff    = signed'({1'b0, i_static_pix}) - signed'({1'b0, i_moving_pix});
        prod    = diff * diff;
        sum_ext = {1'b0, r_acc} + (SUM_W + 1)'(r_sq);
    end

    // Control pipeline, aligned with the registered memory read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s2_last  <= 1'b0;
        end else begin
            r_s1_valid <= i_ctl.valid;
            r_s1_last  <= i_ctl.last;
            r_s2_valid <= r_s1_valid;
            r_s2_last  <= r_s1_last;
        end
    end

    // Squared difference register.
    always_ff @(posedge i_clk) begin
        r_sq <= prod[2*PIX_W-1:0];
    end

    // Saturating accumulator; the done flag marks the final pixel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_done <= 1'b0;
        end else if (i_ctl.start) begin
            r_acc  <= '0;
            r_done <= 1'b0;
        end else begin
            if (r_s2_valid) begin
                r_acc <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
            end
            if (r_s2_last) begin
                r_done <= 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_acc;

endmodule

`default_nettype wire

>>> design/shifted_image_ssd.sv
// Top level of the shifted image SSD block: ports, registers, image memories.
// Depends on ssd_pkg, ssd_ram, ssd_scan and ssd_accum.
//
//  Channel   Handshake                Payload
//  input     i_in_valid / o_in_stall  i_command, i_pos_x, i_pos_y, i_pixel,
//                                     i_shift_x, i_shift_y
//  output    o_out_valid / i_out_stall o_ssd
//  config    APB (psel, penable ...)  active_width at 0x0, active_height at 0x4
//
// A load transaction does not stall the input. An evaluate transaction
// reads one static/moving pixel pair per cycle from the two image memories
// over the width*height frame, then waits while the output is stalled.
// o_in_stall is high from the accepted evaluate until its sum enters the
// output register. Reset clears the control state and sets both dimensions
// to 256; the image memories are not cleared and hold garbage until loaded.
`default_nettype none

module shifted_image_ssd
    import ssd_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    // Input channel.
    input  wire logic                      i_in_valid,
    output logic                           o_in_stall,
    input  wire logic        [1:0]         i_command,
    input  wire logic        [POS_W-1:0]   i_pos_x,
    input  wire logic        [POS_W-1:0]   i_pos_y,
    input  wire logic        [PIX_W-1:0]   i_pixel,
    input  wire logic signed [SHIFT_W-1:0] i_shift_x,
    input  wire logic signed [SHIFT_W-1:0] i_shift_y,
    // Output channel.
    output logic                           o_out_valid,
    input  wire logic                      i_out_stall,
    output logic             [SUM_W-1:0]   o_ssd,
    // Configuration port.
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic        [ADDR_W-1:0]  paddr,
    input  wire logic        [APB_W-1:0]   pwdata,
    output logic             [APB_W-1:0]   prdata,
    output logic                           pready
);

    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int YW    = $clog2(MAX_HEIGHT);
    localparam int AW    = XW + YW;
    localparam int DEPTH = 2 ** AW;

    logic [CFG_W-1:0] r_active_width;
    logic [CFG_W-1:0] r_active_height;
    logic             r_out_valid;
    logic [SUM_W-1:0] r_ssd;

    logic             in_accept;
    logic             load_in_range;
    logic             static_wr;
    logic             moving_wr;
    logic             eval_start;
    logic [AW-1:0]    load_addr;
    logic             busy;
    logic             result_load;
    logic             out_free;
    logic             acc_done;
    logic [SUM_W-1:0] acc_sum;
    t_scan_ctl        scan_ctl;
    logic [AW-1:0]    static_rd_addr;
    logic [AW-1:0]    moving_rd_addr;
    logic [PIX_W-1:0] static_pix;
    logic [PIX_W-1:0] moving_pix;

    // Input transaction decode.
    always_comb begin
        in_accept     = i_in_valid && !o_in_stall;
        load_in_range = (32'(i_pos_x) < MAX_WIDTH) && (32'(i_pos_y) < MAX_HEIGHT);
        static_wr     = in_accept && load_in_range && (i_command == CMD_LOAD_STATIC);
        moving_wr     = in_accept && load_in_range && (i_command == CMD_LOAD_MOVING);
        eval_start    = in_accept && (i_command == CMD_EVALUATE);
        load_addr     = {YW'(i_pos_y), XW'(i_pos_x)};
    end

    assign o_in_stall = busy;
    assign out_free   = !r_out_valid || !i_out_stall;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_width  <= CFG_DIM_RESET;
            r_active_height <= CFG_DIM_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (t_reg_index'(paddr[2]))
                REG_ACTIVE_WIDTH:  r_active_width  <= pwdata[CFG_W-1:0];
                REG_ACTIVE_HEIGHT: r_active_height <= pwdata[CFG_W-1:0];
                default:           r_active_width  <= r_active_width;
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (t_reg_index'(paddr[2]))
            REG_ACTIVE_WIDTH:  prdata = APB_W'(r_active_width);
            REG_ACTIVE_HEIGHT: prdata = APB_W'(r_active_height);
            default:           prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // Image memories.
    ssd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_static_ram (
        .i_clk     (i_clk),
        .i_wr_en   (static_wr),
        .i_wr_addr (load_addr),
        .i_wr_data (i_pixel),
        .i_rd_addr (static_rd_addr),
        .o_rd_data (static_pix)
    );

    ssd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_moving_ram (
        .i_clk     (i_clk),
        .i_wr_en   (moving_wr),
        .i_wr_addr (load_addr),
        .i_wr_data (i_pixel),
        .i_rd_addr (moving_rd_addr),
        .o_rd_data (moving_pix)
    );

    // Frame scan sequencer.
    ssd_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (eval_start),
        .i_shift_x     (i_shift_x),
        .i_shift_y     (i_shift_y),
        .i_cfg_width   (r_active_width),
        .i_cfg_height  (r_active_height),
        .i_done        (acc_done),
        .i_out_free    (out_free),
        .o_busy        (busy),
        .o_result_load (result_load),
        .o_ctl         (scan_ctl),
        .o_static_addr (static_rd_addr),
        .o_moving_addr (moving_rd_addr)
    );

    // Squared difference accumulator.
    ssd_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (scan_ctl),
        .i_static_pix (static_pix),
        .i_moving_pix (moving_pix),
        .o_done       (acc_done),
        .o_sum        (acc_sum)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (result_load) begin
            r_ssd <= acc_sum;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ssd       = r_ssd;

endmodule

`default_nettype wire

>>> test/shifted_image_ssd_test.sv
// Self-checking testbench for shifted_image_ssd: directed table, then random traffic.
// Depends on ssd_pkg and the shifted_image_ssd RTL; needs no files or arguments.
// Expected sums come from an in-bench image store and a shifted-overlap SSD predictor.

module shifted_image_ssd_test
    import ssd_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          HALF_PERIOD      = 4;
    localparam int          SETTLE_CYCLES    = 16;
    localparam int          LONG_HOLD        = 2000;
    localparam int          RANDOM_ITEMS     = 100;
    localparam int          MIN_RANDOM_EVALS = 40;
    localparam int unsigned CYCLE_LIMIT      = 4_000_000;
    localparam int          NUM_PIXELS       = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;

    // Command code that the block must ignore.
    localparam logic [1:0] CMD_UNKNOWN = 2'd3;

    // One row of the directed table: either a register write or an input transaction.
    typedef struct packed {
        logic             is_cfg;
        t_reg_index       cfg_reg;
        logic [CFG_W-1:0] cfg_val;
        logic [1:0]       cmd;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [PIX_W-1:0] pixel;
        logic [SHIFT_W-1:0] shift_x;
        logic [SHIFT_W-1:0] shift_y;
        logic             has_sum;
        logic [SUM_W-1:0] sum;
    } t_step;

    // The images are filled with static 255 and moving 0 before this table runs.
    // Shift codes: 9'h0FF is +255, 9'h101 is -255, 9'h100 is -256, 9'h1FF is -1.
    localparam t_step DIRECTED [25] = '{
        // Full frame after reset: every pixel differs by 255.
        '{1'b0, REG_ACTIVE_WIDTH, 9'd0, CMD_EVALUATE, 8'd0, 8'd0, 8'd0, 9'h000, 9'h000,
          1'b1, 32'd4261478400},
        // Unknown command aimed at the one pixel the next evaluate reads.
        '{1'b0, REG_ACTIVE_WIDTH, 9'd0, CMD_UNKNOWN, 8'd255, 8'd255, 8'd0, 9'h000, 9'h000,
          1'b0, 32'd0},
        // Largest shifts leave a single corner pixel in the overlap.
        '{1'b0, REG_ACTIVE_WIDTH, 9'd0, CMD_EVALUATE, 8'd0, 8'd0, 8'd0, 9'h0FF, 9'h0FF,
          1'b1, 32'd65025},
        '{1'b0, REG_ACTIVE_WIDTH, 9'd0, CMD_EVALUATE, 8'd0, 8'd0, 8'd0, 9'h101, 9'h101,
          1'b1, 32'd65025},
        // A shift of -256 moves everything out of the frame.
        '{1'b0, REG_ACTIVE_WIDTH, 9'd0, CMD_EVALUATE, 8'd0, 8'd0, 8'd0, 9'h100, 9'h100,
          1'b1, 32'd0},
        // One full-width row.
        '{1'b1, REG_ACTIVE_WIDTH, 9'd256, CMD_LOAD_STATIC, 8'd0, 8'd0, 8'd0, 9'h000, 9'h000,
          1'b0, 32'd0},
        '{1'b1, REG_ACTIVE_HEIGHT, 9'd1, CMD_LOAD_STATIC, 8'd0, 8'd0, 8'd0, 9'h000, 9'h000,
          1'b0, 32'd0},
        '{1'b0, REG_ACTIVE_WIDTH, 9'd0, CMD_LOAD_STATIC, 8'd255, 8'd0, 8'd0, 9'h000, 9'h000,
          1'b0, 32'd0},
        '{1'b0, REG_ACTIVE_WIDTH, 9'd0, CMD_LOAD_MOVING, 8'd0, 8'd0, 8'd255, 9'h000, 9'h000,
          1'b0, 32'd0},
        '{1'b0, REG_ACTIVE_WIDTH, 9'd0, CMD_EVALUATE, 8'd0, 8'd0, 8'd0, 9'h000, 9'h000,
          1'b0, 32'd0},
        '{1'b0, REG_ACTIVE_WIDTH, 9'd0, CMD_EVALUATE, 8'd0, 8'd0, 8'd0, 9'h0FF, 9'h000,
          1'b0, 32'd0},
        '{1'b0, REG_ACTIVE_WIDTH, 9'd0, CMD_EVALUATE, 8'd0, 8'd0, 8'd0, 9'h101, 9'h000,
          1'b0, 32'd0},
        // One full-height column.
        '{1'b1, REG_ACTIVE_WIDTH, 9'd1, CMD_LOAD_STATIC, 8'd0, 8'd0, 8'd0, 9'h000, 9'h000,
          1'b0, 32'd0},
        '{1'b1, REG_ACTIVE_HEIGHT, 9'd256, CMD_LOAD_STATIC, 8'd0, 8'd0, 8'd0, 9'h000, 9'h000,
          1'b0, 32'd0},
        '{1'b0, REG_ACTIVE_WIDTH, 9'd0, CMD_LOAD_MOVING, 8'd0, 8'd255, 8'h80, 9'h000, 9'h000,
          1'b0, 32'd0},
        '{1'b0, REG_ACTIVE_WIDTH, 9'd0, CMD_EVALUATE, 8'd0, 8'd0, 8'd0, 9'h000, 9'h101,
          1'b0, 32'd0},
        '{1'b0, REG_ACTIVE_WIDTH, 9'd0, CMD_EVALUATE, 8'd0, 8'd0, 8'd0, 9'h000, 9'h001,
          1'b0, 32'd0},
        // Out-of-range register values saturate to 1 and 256.
        '{1'b1, REG_ACTIVE_WIDTH, 9'd0, CMD_LOAD_STATIC, 8'd0, 8'd0, 8'd0, 9'h000, 9'h000,
          1'b0, 32'd0},
        '{1'b1, REG_ACTIVE_HEIGHT, 9'd511, CMD_LOAD_STATIC, 8'd0, 8'd0, 8'd0, 9'h000, 9'h000,
          1'b0, 32'd0},
        '{1'b0, REG_ACTIVE_WIDTH, 9'd0, CMD_EVALUATE, 8'd0, 8'd0, 8'd0, 9'h000, 9'h000,
          1'b0, 32'd0},
        // Smallest frame that still allows a diagonal shift.
        '{1'b1, REG_ACTIVE_WIDTH, 9'd2, CMD_LOAD_STATIC, 8'd0, 8'd0, 8'd0, 9'h000, 9'h000,
          1'b0, 32'd0},
        '{1'b1, REG_ACTIVE_HEIGHT, 9'd2, CMD_LOAD_STATIC, 8'd0, 8'd0, 8'd0, 9'h000, 9'h000,
          1'b0, 32'd0},
        '{1'b0, REG_ACTIVE_WIDTH, 9'd0, CMD_LOAD_STATIC, 8'd1, 8'd1, 8'h5A, 9'h000, 9'h000,
          1'b0, 32'd0},
        '{1'b0, REG_ACTIVE_WIDTH, 9'd0, CMD_EVALUATE, 8'd0, 8'd0, 8'd0, 9'h1FF, 9'h001,
          1'b0, 32'd0},
        '{1'b0, REG_ACTIVE_WIDTH, 9'd0, CMD_EVALUATE, 8'd0, 8'd0, 8'd0, 9'h001, 9'h1FF,
          1'b0, 32'd0}
    };

    // Clock, reset and block signals.
    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      in_valid  = 1'b0;
    logic [1:0]                in_cmd    = 2'd0;
    logic [POS_W-1:0]          in_x      = '0;
    logic [POS_W-1:0]          in_y      = '0;
    logic [PIX_W-1:0]          in_pix    = '0;
    logic signed [SHIFT_W-1:0] in_sx     = '0;
    logic signed [SHIFT_W-1:0] in_sy     = '0;
    logic                      out_stall = 1'b0;
    logic                      psel      = 1'b0;
    logic                      penable   = 1'b0;
    logic                      pwrite    = 1'b0;
    logic [ADDR_W-1:0]         paddr     = '0;
    logic [APB_W-1:0]          pwdata    = '0;
    logic                      in_stall;
    logic                      out_valid;
    logic [SUM_W-1:0]          ssd;
    logic [APB_W-1:0]          prdata;
    logic                      pready;

    // Predictor state: both images and the raw dimension registers.
    bit   [PIX_W-1:0] static_pix [NUM_PIXELS];
    bit   [PIX_W-1:0] moving_pix [NUM_PIXELS];
    logic [CFG_W-1:0] frame_w_raw = CFG_DIM_RESET;
    logic [CFG_W-1:0] frame_h_raw = CFG_DIM_RESET;
    logic [SUM_W-1:0] sums_due [$];

    // Idling plan and run statistics.
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          long_hold_go  = 1'b0;
    bit          hold_started  = 1'b0;
    int          hold_left     = 0;
    int unsigned cycle_count   = 0;
    int          mismatch_count = 0;
    int          load_count    = 0;
    int          eval_count    = 0;
    int          full_evals    = 0;
    int          cfg_writes    = 0;
    int          random_items  = 0;
    int          random_evals  = 0;

    shifted_image_ssd DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_command   (in_cmd),
        .i_pos_x     (in_x),
        .i_pos_y     (in_y),
        .i_pixel     (in_pix),
        .i_shift_x   (in_sx),
        .i_shift_y   (in_sy),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_ssd       (ssd),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Free-running clock.
    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles with %0d sums outstanding.",
                 cycle_count, sums_due.size());
        $display("== FAIL ==");
        $finish;
    end

    // Dimension register as the block uses it, saturated to 1..256.
    function automatic int frame_dim(logic [CFG_W-1:0] raw);
        if (raw == '0) return 1;
        if (raw > 9'd256) return 256;
        return int'(raw);
    endfunction

    // Sum of squared differences between the static image and the shifted moving image.
    function automatic logic [SUM_W-1:0] shifted_ssd(logic signed [SHIFT_W-1:0] sx,
                                                     logic signed [SHIFT_W-1:0] sy);
        int              w;
        int              h;
        int              mx;
        int              my;
        int              d;
        longint unsigned acc;
        w   = frame_dim(frame_w_raw);
        h   = frame_dim(frame_h_raw);
        acc = 0;
        for (int y = 0; y < h; y++) begin
            my = y - int'(sy);
            if (my < 0 || my >= h) continue;
            for (int x = 0; x < w; x++) begin
                mx = x - int'(sx);
                if (mx < 0 || mx >= w) continue;
                d = int'(static_pix[y * DEF_MAX_WIDTH + x])
                  - int'(moving_pix[my * DEF_MAX_WIDTH + mx]);
                acc += longint'(d * d);
            end
        end
        if (acc > 64'hFFFF_FFFF) acc = 64'hFFFF_FFFF;
        return acc[SUM_W-1:0];
    endfunction

    // Random shift: mostly within the frame, sometimes any 9-bit code.
    function automatic logic [SHIFT_W-1:0] rand_shift(int span);
        int s;
        s = (span > 255) ? 255 : span;
        if ($urandom_range(99) < 80) return SHIFT_W'($urandom_range(2 * s) - s);
        return SHIFT_W'($urandom_range(511));
    endfunction

    task automatic report_mismatch(string what, logic [SUM_W-1:0] got,
                                   logic [SUM_W-1:0] want);
        $display("Mismatch at %0t: %s, got %0d, expected %0d.", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic apply_idle_plan(int plan);
        case (plan)
            0: begin
                send_idle_pct = 23;
                recv_idle_pct = 76;
            end
            1: begin
                send_idle_pct = 76;
                recv_idle_pct = 23;
            end
            default: begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
        endcase
    endtask

    // Offer one transaction, wait until it is accepted, then update the predictor.
    task automatic send_item(logic [1:0] cmd, logic [POS_W-1:0] px, logic [POS_W-1:0] py,
                             logic [PIX_W-1:0] pix, logic [SHIFT_W-1:0] sx,
                             logic [SHIFT_W-1:0] sy, bit has_sum, logic [SUM_W-1:0] sum);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_cmd   <= cmd;
        in_x     <= px;
        in_y     <= py;
        in_pix   <= pix;
        in_sx    <= sx;
        in_sy    <= sy;
        do @(posedge clk); while (in_stall);
        case (cmd)
            CMD_LOAD_STATIC: begin
                static_pix[{py, px}] = pix;
                load_count++;
            end
            CMD_LOAD_MOVING: begin
                moving_pix[{py, px}] = pix;
                load_count++;
            end
            CMD_EVALUATE: begin
                sums_due = {sums_due, (has_sum ? sum : shifted_ssd(sx, sy))};
                eval_count++;
                if (frame_dim(frame_w_raw) * frame_dim(frame_h_raw) == NUM_PIXELS)
                    full_evals++;
            end
            default: ;  // Unknown command: no effect, no result.
        endcase
    endtask

    task automatic send_random_eval(int fw, int fh);
        send_item(CMD_EVALUATE, POS_W'($urandom), POS_W'($urandom), PIX_W'($urandom),
                  rand_shift(fw), rand_shift(fh), 1'b0, '0);
        random_items++;
        random_evals++;
    endtask

    // Drop valid and wait until every sum has arrived and the last load has drained.
    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sums_due.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready; then read the value back.
    task automatic write_register(t_reg_index idx, logic [CFG_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (idx == REG_ACTIVE_WIDTH) frame_w_raw = value;
        else frame_h_raw = value;
        cfg_writes++;
        @(negedge clk);
        if (prdata !== APB_W'(value)) report_mismatch("register read-back", prdata,
                                                      APB_W'(value));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold-off to back the block up.
    always @(negedge clk) begin
        if (long_hold_go && !hold_started) begin
            hold_started = 1'b1;
            hold_left    = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Result checker: each accepted transaction against the oldest expected sum.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (sums_due.size() == 0) begin
                report_mismatch("result with no sum expected", ssd, '0);
            end else begin
                if (ssd !== sums_due[0]) report_mismatch("ssd", ssd, sums_due[0]);
                void'(sums_due.pop_front());
            end
        end
    end

    // Stimulus.
    initial begin
        logic [CFG_W-1:0] w_raw;
        logic [CFG_W-1:0] h_raw;
        int               fw;
        int               fh;
        int               n_items;
        int               pick;
        int               r;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        apply_idle_plan(0);

        // Write every pixel of both images so that no evaluate reads unwritten storage.
        for (int y = 0; y < DEF_MAX_HEIGHT; y++) begin
            for (int x = 0; x < DEF_MAX_WIDTH; x++) begin
                send_item(CMD_LOAD_STATIC, POS_W'(x), POS_W'(y), 8'hFF, '0, '0, 1'b0, '0);
                send_item(CMD_LOAD_MOVING, POS_W'(x), POS_W'(y), 8'h00, '0, '0, 1'b0, '0);
            end
        end

        // Directed table.
        foreach (DIRECTED[i]) begin
            if (DIRECTED[i].is_cfg) begin
                settle_block();
                write_register(DIRECTED[i].cfg_reg, DIRECTED[i].cfg_val);
            end else begin
                send_item(DIRECTED[i].cmd, DIRECTED[i].pos_x, DIRECTED[i].pos_y,
                          DIRECTED[i].pixel, DIRECTED[i].shift_x, DIRECTED[i].shift_y,
                          DIRECTED[i].has_sum, DIRECTED[i].sum);
            end
        end

        // Random part: a new frame per burst, then random loads, evaluates and unknown commands, ending in an evaluate.
        while (random_items < RANDOM_ITEMS || random_evals < MIN_RANDOM_EVALS) begin
            if (random_items < 34) apply_idle_plan(0);
            else if (random_items < 67) apply_idle_plan(1);
            else apply_idle_plan(2);

            // Once, hold the output off while evaluates keep coming.
            if (random_items >= 67 && !long_hold_go) begin
                long_hold_go = 1'b1;
                repeat (4) send_random_eval(frame_dim(frame_w_raw), frame_dim(frame_h_raw));
            end

            r = $urandom_range(99);
            if (r < 70) begin
                w_raw = CFG_W'($urandom_range(1, 8));
                h_raw = CFG_W'($urandom_range(1, 8));
            end else if (r < 90) begin
                w_raw = CFG_W'($urandom_range(1, 24));
                h_raw = CFG_W'($urandom_range(1, 24));
            end else if (r < 95) begin
                w_raw = CFG_W'($urandom_range(200, 511));
                h_raw = CFG_W'($urandom_range(0, 3));
            end else begin
                w_raw = CFG_W'($urandom_range(0, 3));
                h_raw = CFG_W'($urandom_range(200, 511));
            end
            settle_block();
            write_register(REG_ACTIVE_WIDTH, w_raw);
            write_register(REG_ACTIVE_HEIGHT, h_raw);
            fw = frame_dim(frame_w_raw);
            fh = frame_dim(frame_h_raw);

            n_items = $urandom_range(3, 10);
            for (int i = 0; i < n_items; i++) begin
                pick = $urandom_range(99);
                if (i == n_items - 1 || pick < 20) begin
                    send_random_eval(fw, fh);
                end else if (pick < 72) begin
                    send_item($urandom_range(1) ? CMD_LOAD_MOVING : CMD_LOAD_STATIC,
                              POS_W'($urandom_range(fw - 1)), POS_W'($urandom_range(fh - 1)),
                              PIX_W'($urandom), SHIFT_W'($urandom), SHIFT_W'($urandom),
                              1'b0, '0);
                    random_items++;
                end else if (pick < 90) begin
                    // Load at any position, often outside the active frame: stored, but there read only after a resize.
                    send_item($urandom_range(1) ? CMD_LOAD_MOVING : CMD_LOAD_STATIC,
                              POS_W'($urandom), POS_W'($urandom), PIX_W'($urandom),
                              '0, '0, 1'b0, '0);
                    random_items++;
                end else begin
                    send_item(CMD_UNKNOWN, POS_W'($urandom), POS_W'($urandom),
                              PIX_W'($urandom), SHIFT_W'($urandom), SHIFT_W'($urandom),
                              1'b0, '0);
                end
            end
        end

        settle_block();
        $display("Run covered %0d loads, %0d evaluations (%0d on the full 256x256 frame)",
                 load_count, eval_count, full_evals);
        $display("and %0d register writes, with a %0d-cycle output hold-off under load.",
                 cfg_writes, LONG_HOLD);
        if (mismatch_count == 0 && sums_due.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

>>> sim.f
design/ssd_pkg.sv
design/ssd_ram.sv
design/ssd_scan.sv
design/ssd_accum.sv
design/shifted_image_ssd.sv
test/shifted_image_ssd_test.sv
